FILE: rtl/core/hpl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpl_pkg
// Shared widths, fixed-point constants and bus types of the helix path
// length pipeline.
// ----------------------------------------------------------------------------
package hpl_pkg;

  // Field widths
  localparam int COORD_W = 24;
  localparam int CURV_W  = 32;
  localparam int LEN_W   = 32;

  // Q30 fixed point
  localparam int Q_W = 31;
  localparam logic [Q_W-1:0] Q_ONE     = 31'h4000_0000;
  localparam logic [Q_W-1:0] INV_SQRT2 = 31'd759250124;
  localparam logic [Q_W-1:0] HALF_PI   = 31'd1686629713;

  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  // Square root chain: one result bit per cell
  localparam int SQ_STEPS  = 34;
  localparam int SQ_ROOT_W = 34;
  localparam int SQ_RAD_W  = 2 * SQ_STEPS;
  localparam int SQ_REM_W  = SQ_ROOT_W + 2;

  // asin(v)/v series and divider chains
  localparam int SER_TERMS = 32;
  localparam int SUM_W     = 32;
  localparam int DCON_W    = 7;
  localparam int DIV_STEPS = 32;
  localparam int DIV_W     = 32;

  // Sideband carried alongside the chains
  localparam int SB_W = 128;

  typedef struct packed {
    logic clamped;
    logic kz;
    logic big;
  } flags_t;

  typedef struct packed {
    logic [COORD_W-1:0] az;
    logic [CURV_W-1:0]  ak;
  } a_sb_t;

  typedef struct packed {
    logic [31:0]        cf;
    logic [COORD_W-1:0] az;
    logic [Q_W-1:0]     u;
    flags_t             fl;
  } b_sb_t;

  typedef struct packed {
    logic [31:0]        cf;
    logic [COORD_W-1:0] az;
    logic [Q_W-1:0]     u;
    logic [Q_W-1:0]     w;
    flags_t             fl;
  } s_sb_t;

  typedef struct packed {
    logic [31:0]        cf;
    logic [COORD_W-1:0] az;
    logic [SUM_W-1:0]   gs;
    flags_t             fl;
  } d_sb_t;

  localparam int A_SB_W = $bits(a_sb_t);
  localparam int B_SB_W = $bits(b_sb_t);
  localparam int S_SB_W = $bits(s_sb_t);
  localparam int D_SB_W = $bits(d_sb_t);

  // Square root cell bus
  typedef struct packed {
    logic [SQ_RAD_W-1:0]  rad;
    logic [SQ_REM_W-1:0]  rem;
    logic [SQ_ROOT_W-1:0] root;
    logic [SB_W-1:0]      sb;
  } sq_t;

  // Series term bus
  typedef struct packed {
    logic [Q_W-1:0]   v2;
    logic [Q_W-1:0]   p;
    logic [SUM_W-1:0] sum;
    logic [SB_W-1:0]  sb;
  } ser_t;

  // Per-term divisors and their reciprocals (floor(2^31/d))
  typedef struct packed {
    logic [DCON_W-1:0] d1;
    logic [Q_W-1:0]    m1;
    logic [DCON_W-1:0] d2;
    logic [Q_W-1:0]    m2;
  } ser_k_t;

  // Divider cell bus
  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [DIV_W-1:0] q;
    logic [DIV_W-1:0] nb;
    logic [Q_W-1:0]   dvsr;
    logic [SB_W-1:0]  sb;
  } dv_t;

  // Result transfer
  typedef struct packed {
    logic [LEN_W-1:0] path_length;
    logic             domain_clamped;
    logic             saturated;
  } res_t;

endpackage

FILE: rtl/core/hpl_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpl_sqrt_cell
// One step of a restoring integer square root: brings in two radicand bits
// and decides one root bit, then hands the partial result to the next cell.
// ----------------------------------------------------------------------------
module hpl_sqrt_cell (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         adv,
  input  logic         in_vld,
  input  hpl_pkg::sq_t in_d,
  output logic         out_vld,
  output hpl_pkg::sq_t out_d
);
  import hpl_pkg::*;

  logic [SQ_REM_W-1:0] rem_s;
  logic [SQ_REM_W-1:0] trial;
  logic                ge;
  sq_t                 d_nxt;
  sq_t                 d_r;
  logic                vld_r;

  // Trial subtract of (4*root + 1)
  always_comb begin
    rem_s      = {in_d.rem[SQ_REM_W-3:0], in_d.rad[SQ_RAD_W-1 -: 2]};
    trial      = {in_d.root, 2'b01};
    ge         = (rem_s >= trial);
    d_nxt.rad  = in_d.rad << 2;
    d_nxt.rem  = ge ? (rem_s - trial) : rem_s;
    d_nxt.root = {in_d.root[SQ_ROOT_W-2:0], ge};
    d_nxt.sb   = in_d.sb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_r <= d_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_d   = d_r;

endmodule

FILE: rtl/core/hpl_series_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpl_series_cell
// One term of the asin(v)/v power series over five pipeline stages:
// p = p*v2, p = p*(2n+1)/(2n+2), sum += p/(2n+3). Constant divides use a
// reciprocal multiply with one correction step.
// ----------------------------------------------------------------------------
module hpl_series_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  hpl_pkg::ser_k_t k,
  input  logic            in_vld,
  input  hpl_pkg::ser_t   in_d,
  output logic            out_vld,
  output hpl_pkg::ser_t   out_d
);
  import hpl_pkg::*;

  localparam int PW = 2 * Q_W;
  localparam int RW = Q_W + DCON_W;

  logic [4:0]     vld_r;
  ser_t           c1_r, c2_r, c3_r, c4_r, out_r;
  logic [PW-1:0]  prod1_r;
  logic [Q_W-1:0] p1_r, x1_r;
  logic [PW-1:0]  mq2_r;
  logic [Q_W-1:0] p2_r, p2b_r;
  logic [PW-1:0]  mq4_r;

  logic [Q_W-1:0] p1, x1, q0a, qa, p2, q0b, qb;
  logic [RW-1:0]  ra, rb;
  logic [SUM_W-1:0] sum_nxt;

  // Stage datapath
  always_comb begin
    p1  = prod1_r[PW-2:Q_W-1];
    x1  = p1 + Q_W'(k.d1) - Q_W'(1);
    // ceil(p/d1) = floor((p+d1-1)/d1)
    q0a = mq2_r[PW-1:Q_W];
    ra  = RW'(x1_r) - RW'(q0a) * RW'(k.d1);
    qa  = q0a + Q_W'(ra >= RW'(k.d1));
    p2  = p1_r - qa;
    // floor(p/d2)
    q0b = mq4_r[PW-1:Q_W];
    rb  = RW'(p2b_r) - RW'(q0b) * RW'(k.d2);
    qb  = q0b + Q_W'(rb >= RW'(k.d2));
    sum_nxt = c4_r.sum + SUM_W'(qb);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[3:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c1_r    <= in_d;
      prod1_r <= PW'(in_d.p) * PW'(in_d.v2);
      c2_r    <= c1_r;
      p1_r    <= p1;
      x1_r    <= x1;
      mq2_r   <= PW'(x1) * PW'(k.m1);
      c3_r    <= c2_r;
      p2_r    <= p2;
      c4_r    <= c3_r;
      p2b_r   <= p2_r;
      mq4_r   <= PW'(p2_r) * PW'(k.m2);
      out_r.v2  <= c4_r.v2;
      out_r.p   <= p2b_r;
      out_r.sum <= sum_nxt;
      out_r.sb  <= c4_r.sb;
    end
  end

  assign out_vld = vld_r[4];
  assign out_d   = out_r;

endmodule

FILE: rtl/core/hpl_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpl_div_cell
// One step of restoring division: shifts in one dividend bit, decides one
// quotient bit and passes the partial remainder on.
// ----------------------------------------------------------------------------
module hpl_div_cell (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         adv,
  input  logic         in_vld,
  input  hpl_pkg::dv_t in_d,
  output logic         out_vld,
  output hpl_pkg::dv_t out_d
);
  import hpl_pkg::*;

  logic [DIV_W-1:0] rs;
  logic             ge;
  dv_t              d_nxt;
  dv_t              d_r;
  logic             vld_r;

  // Remainder stays below the divisor, so its top bit is free
  always_comb begin
    rs         = {in_d.rem[DIV_W-2:0], in_d.nb[DIV_W-1]};
    ge         = (rs >= DIV_W'(in_d.dvsr));
    d_nxt.rem  = ge ? (rs - DIV_W'(in_d.dvsr)) : rs;
    d_nxt.q    = {in_d.q[DIV_W-2:0], ge};
    d_nxt.nb   = in_d.nb << 1;
    d_nxt.dvsr = in_d.dvsr;
    d_nxt.sb   = in_d.sb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_r <= d_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_d   = d_r;

endmodule

FILE: rtl/core/helix_path_length.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// helix_path_length
// Path length along a helix between two points, from the transverse chord
// and the curvature, in fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries begin and end points and the
//   track curvature; the result channel (out_valid / out_stall) returns the
//   length in 1/256 cm with a domain clamp flag and a saturation flag.
//   Throughput is one transfer per cycle while in_stall is low. The pipeline
//   is made up of the three 34-cell square root chains, the 32 five-stage
//   series cells for asin(v)/v and the 32-cell divider, plus the multiply
//   stages between them.
//   The whole pipeline moves on one advance enable. A two-entry output
//   buffer holds finished results; while one result waits, the pipeline
//   keeps advancing and new items are still taken. in_stall rises only when
//   the buffer is full, the last stage holds a result and out_stall is high.
//   Synchronous reset clears all valid bits and empties the buffer.
// ----------------------------------------------------------------------------
module helix_path_length (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [hpl_pkg::COORD_W-1:0] in_begin_x,
  input  logic signed [hpl_pkg::COORD_W-1:0] in_begin_y,
  input  logic signed [hpl_pkg::COORD_W-1:0] in_begin_z,
  input  logic signed [hpl_pkg::COORD_W-1:0] in_end_x,
  input  logic signed [hpl_pkg::COORD_W-1:0] in_end_y,
  input  logic signed [hpl_pkg::COORD_W-1:0] in_end_z,
  input  logic signed [hpl_pkg::CURV_W-1:0]  in_track_curvature,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [hpl_pkg::LEN_W-1:0]         out_path_length,
  output logic                              out_domain_clamped,
  output logic                              out_saturated
);
  import hpl_pkg::*;

  function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                  input logic [COORD_W-1:0] b);
    logic [COORD_W:0] d;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    return d[COORD_W] ? COORD_W'(-d) : d[COORD_W-1:0];
  endfunction

  logic adv;
  logic [14:0] sv_r;

  // Stage registers
  logic [COORD_W-1:0] ax0_r, ay0_r, az0_r, az1_r, az3_r, az4_r, az5_r;
  logic [COORD_W-1:0] az9_r, az11_r;
  logic [CURV_W-1:0]  ak0_r, ak1_r;
  logic [2*COORD_W-1:0] sx1_r, sy1_r;
  sq_t   a_in_r, b_in_r, c_in_r;
  logic [63:0] prod3_r, prod11_r;
  logic [31:0] cf3_r, cf4_r, cf5_r, cf9_r, cf11_r;
  logic        kz3_r, kz11_r, cl11_r, cl12_r, cl13_r;
  logic [Q_W-1:0] u4_r, u5_r, u9_r;
  flags_t      fl4_r, fl5_r, fl9_r;
  logic [2*Q_W-1:0] uu5_r, vv7_r;
  s_sb_t       s7_r;
  ser_t        s_in_r;
  logic [62:0] ap9_r;
  logic [SUM_W-1:0] gs9_r;
  dv_t         d_in_r;
  logic [32:0] arc12_r;
  logic [30:0] z12_r;
  logic [65:0] aa13_r;
  logic [61:0] zz13_r;

  // Chain wires
  sq_t  a_d [SQ_STEPS+1];
  sq_t  b_d [SQ_STEPS+1];
  sq_t  c_d [SQ_STEPS+1];
  logic [SQ_STEPS:0] a_v, b_v, c_v;
  ser_t s_d [SER_TERMS+1];
  logic [SER_TERMS:0] s_v;
  dv_t  d_d [DIV_STEPS+1];
  logic [DIV_STEPS:0] d_v;

  // Stage combinational values
  logic [CURV_W-1:0] ak_in;
  a_sb_t a_sb;
  b_sb_t b_sb;
  s_sb_t s_sb;
  d_sb_t d_sb;
  logic [31:0]   a_cf;
  logic [37:0]   uw;
  logic          clamped;
  logic [Q_W-1:0] u_c, v_c, theta;
  logic [60:0]   rad_b;
  logic [32:0]   a_val;
  logic [31:0]   g_c;
  logic [SQ_ROOT_W:0] t_rnd;
  logic [27:0]   len;
  res_t          res;

  // Output buffer
  res_t        head_r, tail_r, head_nxt, tail_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push, pop;

  assign ak_in = in_track_curvature[CURV_W-1] ? (~in_track_curvature + CURV_W'(1))
                                              : in_track_curvature;

  // Valid bits of the plain stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= '0;
    end else if (adv) begin
      sv_r[0]  <= in_valid;
      sv_r[1]  <= sv_r[0];
      sv_r[2]  <= sv_r[1];
      sv_r[3]  <= a_v[SQ_STEPS];
      sv_r[4]  <= sv_r[3];
      sv_r[5]  <= sv_r[4];
      sv_r[6]  <= sv_r[5];
      sv_r[7]  <= b_v[SQ_STEPS];
      sv_r[8]  <= sv_r[7];
      sv_r[9]  <= s_v[SER_TERMS];
      sv_r[10] <= sv_r[9];
      sv_r[11] <= d_v[DIV_STEPS];
      sv_r[12] <= sv_r[11];
      sv_r[13] <= sv_r[12];
      sv_r[14] <= sv_r[13];
    end
  end

  // Sideband unpacking and per-stage arithmetic
  always_comb begin
    a_sb  = a_sb_t'(a_d[SQ_STEPS].sb[A_SB_W-1:0]);
    b_sb  = b_sb_t'(b_d[SQ_STEPS].sb[B_SB_W-1:0]);
    s_sb  = s_sb_t'(s_d[SER_TERMS].sb[S_SB_W-1:0]);
    d_sb  = d_sb_t'(d_d[DIV_STEPS].sb[D_SB_W-1:0]);
    a_cf  = a_d[SQ_STEPS].root[31:0];
    // u = cf*|k| / 2^26, clamped to one
    uw      = prod3_r[63:26];
    clamped = (uw > 38'(Q_ONE));
    u_c     = clamped ? Q_ONE : uw[Q_W-1:0];
    rad_b   = (61'(1) << 60) - uu5_r[60:0];
    v_c     = b_sb.fl.big ? b_d[SQ_STEPS].root[Q_W-1:0] : b_sb.u;
    // theta = pi/2 - w*series(v)
    a_val   = ap9_r[62:30];
    theta   = (a_val < 33'(HALF_PI)) ? (HALF_PI - a_val[Q_W-1:0]) : '0;
    g_c     = d_sb.fl.big ? d_d[DIV_STEPS].q : d_sb.gs;
    // Round half up and saturate
    t_rnd   = (SQ_ROOT_W+1)'(c_d[SQ_STEPS].root) + (SQ_ROOT_W+1)'(64);
    len     = t_rnd[SQ_ROOT_W:7];
    res.saturated      = (64'(len) > 64'(LEN_MAX));
    res.path_length    = res.saturated ? LEN_MAX : LEN_W'(len);
    res.domain_clamped = c_d[SQ_STEPS].sb[0];
  end

  // Pipeline payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      // Differences and curvature magnitude
      ax0_r <= abs_diff(in_end_x, in_begin_x);
      ay0_r <= abs_diff(in_end_y, in_begin_y);
      az0_r <= abs_diff(in_end_z, in_begin_z);
      ak0_r <= ak_in;
      // Squares
      sx1_r <= (2*COORD_W)'(ax0_r) * (2*COORD_W)'(ax0_r);
      sy1_r <= (2*COORD_W)'(ay0_r) * (2*COORD_W)'(ay0_r);
      az1_r <= az0_r;
      ak1_r <= ak0_r;
      // Chord radicand S * 2^14
      a_in_r.rad  <= SQ_RAD_W'({(2*COORD_W+1)'(sx1_r) + (2*COORD_W+1)'(sy1_r), 14'd0});
      a_in_r.rem  <= '0;
      a_in_r.root <= '0;
      a_in_r.sb   <= SB_W'(a_sb_t'{az: az1_r, ak: ak1_r});
      // cf * |k|
      prod3_r <= 64'(a_cf) * 64'(a_sb.ak);
      cf3_r   <= a_cf;
      az3_r   <= a_sb.az;
      kz3_r   <= (a_sb.ak == '0);
      // u and its flags
      u4_r     <= u_c;
      fl4_r    <= '{clamped: clamped, kz: kz3_r, big: (u_c > INV_SQRT2)};
      cf4_r    <= cf3_r;
      az4_r    <= az3_r;
      // u^2
      uu5_r <= (2*Q_W)'(u4_r) * (2*Q_W)'(u4_r);
      u5_r  <= u4_r;
      fl5_r <= fl4_r;
      cf5_r <= cf4_r;
      az5_r <= az4_r;
      // w = sqrt(1 - u^2)
      b_in_r.rad  <= SQ_RAD_W'(rad_b);
      b_in_r.rem  <= '0;
      b_in_r.root <= '0;
      b_in_r.sb   <= SB_W'(b_sb_t'{cf: cf5_r, az: az5_r, u: u5_r, fl: fl5_r});
      // Series argument squared
      vv7_r <= (2*Q_W)'(v_c) * (2*Q_W)'(v_c);
      s7_r  <= '{cf: b_sb.cf, az: b_sb.az, u: b_sb.u,
                 w: b_d[SQ_STEPS].root[Q_W-1:0], fl: b_sb.fl};
      s_in_r.v2  <= vv7_r[2*Q_W-2:Q_W-1];
      s_in_r.p   <= Q_ONE;
      s_in_r.sum <= SUM_W'(Q_ONE);
      s_in_r.sb  <= SB_W'(s7_r);
      // w * series(v); v is w when u is big, else u
      ap9_r <= 63'(s_sb.w) * 63'(s_d[SER_TERMS].sum);
      gs9_r <= s_d[SER_TERMS].sum;
      cf9_r <= s_sb.cf;
      az9_r <= s_sb.az;
      u9_r  <= s_sb.u;
      fl9_r <= s_sb.fl;
      // Divide theta * 2^30 by u
      d_in_r.rem  <= DIV_W'(theta[Q_W-1:2]);
      d_in_r.q    <= '0;
      d_in_r.nb   <= {theta[1:0], 30'd0};
      d_in_r.dvsr <= u9_r;
      d_in_r.sb   <= SB_W'(d_sb_t'{cf: cf9_r, az: az9_r, gs: gs9_r, fl: fl9_r});
      // Arc = cf * g
      prod11_r <= 64'(d_sb.cf) * 64'(g_c);
      cf11_r   <= d_sb.cf;
      az11_r   <= d_sb.az;
      kz11_r   <= d_sb.fl.kz;
      cl11_r   <= d_sb.fl.clamped;
      arc12_r  <= kz11_r ? 33'(cf11_r) : prod11_r[62:30];
      z12_r    <= {az11_r, 7'd0};
      cl12_r   <= cl11_r;
      // Squares of arc and dz
      aa13_r <= 66'(arc12_r) * 66'(arc12_r);
      zz13_r <= 62'(z12_r) * 62'(z12_r);
      cl13_r <= cl12_r;
      c_in_r.rad  <= SQ_RAD_W'(67'(aa13_r) + 67'(zz13_r));
      c_in_r.rem  <= '0;
      c_in_r.root <= '0;
      c_in_r.sb   <= SB_W'(cl13_r);
    end
  end

  // Chord square root chain
  assign a_d[0] = a_in_r;
  assign a_v[0] = sv_r[2];
  // Chain for sqrt(1 - u^2)
  assign b_d[0] = b_in_r;
  assign b_v[0] = sv_r[6];
  // Total length square root chain
  assign c_d[0] = c_in_r;
  assign c_v[0] = sv_r[14];

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sq
    hpl_sqrt_cell u_a (
      .clk(clk), .rst_n(rst_n), .adv(adv),
      .in_vld(a_v[i]), .in_d(a_d[i]), .out_vld(a_v[i+1]), .out_d(a_d[i+1])
    );
    hpl_sqrt_cell u_b (
      .clk(clk), .rst_n(rst_n), .adv(adv),
      .in_vld(b_v[i]), .in_d(b_d[i]), .out_vld(b_v[i+1]), .out_d(b_d[i+1])
    );
    hpl_sqrt_cell u_c (
      .clk(clk), .rst_n(rst_n), .adv(adv),
      .in_vld(c_v[i]), .in_d(c_d[i]), .out_vld(c_v[i+1]), .out_d(c_d[i+1])
    );
  end

  // asin(v)/v series chain
  assign s_d[0] = s_in_r;
  assign s_v[0] = sv_r[8];

  for (genvar i = 0; i < SER_TERMS; i++) begin : g_ser
    localparam int D1 = 2 * i + 2;
    localparam int D2 = 2 * i + 3;
    localparam logic [Q_W-1:0] M1 = Q_W'((64'd1 << 31) / D1);
    localparam logic [Q_W-1:0] M2 = Q_W'((64'd1 << 31) / D2);
    ser_k_t k;
    assign k = '{d1: DCON_W'(D1), m1: M1, d2: DCON_W'(D2), m2: M2};
    hpl_series_cell u_term (
      .clk(clk), .rst_n(rst_n), .adv(adv), .k(k),
      .in_vld(s_v[i]), .in_d(s_d[i]), .out_vld(s_v[i+1]), .out_d(s_d[i+1])
    );
  end

  // Divider chain
  assign d_d[0] = d_in_r;
  assign d_v[0] = sv_r[10];

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    hpl_div_cell u_step (
      .clk(clk), .rst_n(rst_n), .adv(adv),
      .in_vld(d_v[i]), .in_d(d_d[i]), .out_vld(d_v[i+1]), .out_d(d_d[i+1])
    );
  end

  // Output buffer and advance control
  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign adv       = !c_v[SQ_STEPS] || (cnt_r != 2'd2) || pop;
  assign push      = adv && c_v[SQ_STEPS];
  assign in_stall  = !adv;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    case (cnt_r)
      2'd0: begin
        if (push) begin
          head_nxt = res;
          cnt_nxt  = 2'd1;
        end
      end
      2'd1: begin
        if (push && pop) begin
          head_nxt = res;
        end else if (push) begin
          tail_nxt = res;
          cnt_nxt  = 2'd2;
        end else if (pop) begin
          cnt_nxt  = 2'd0;
        end
      end
      default: begin
        if (pop) begin
          head_nxt = tail_r;
          if (push) begin
            tail_nxt = res;
          end else begin
            cnt_nxt = 2'd1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

  assign out_path_length    = head_r.path_length;
  assign out_domain_clamped = head_r.domain_clamped;
  assign out_saturated      = head_r.saturated;

endmodule
